>>> rtl/assert_macros.svh
// Assertion shorthands for the RTL, included by pvc_ctrl.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> rtl/pvc_pkg.sv
package pvc_pkg;

	localparam logic CMD_LOAD    = 1'b0;
	localparam logic CMD_COMPARE = 1'b1;

	localparam logic [1:0] SLOT_VER_A = 2'd0;
	localparam logic [1:0] SLOT_REV_A = 2'd1;
	localparam logic [1:0] SLOT_VER_B = 2'd2;
	localparam logic [1:0] SLOT_REV_B = 2'd3;

	localparam logic [2:0] REL_NONE = 3'd0;
	localparam logic [2:0] REL_EQ   = 3'd1;
	localparam logic [2:0] REL_LT   = 3'd2;
	localparam logic [2:0] REL_LE   = 3'd3;
	localparam logic [2:0] REL_GT   = 3'd4;
	localparam logic [2:0] REL_GE   = 3'd5;

	localparam logic signed [1:0] SIGN_NEG  = -2'sd1;
	localparam logic signed [1:0] SIGN_ZERO = 2'sd0;
	localparam logic signed [1:0] SIGN_POS  = 2'sd1;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_Z  = 8'h7A;
	localparam logic [7:0] CH_TILDE = 8'h7E;

	typedef logic signed [9:0] weight_t;

	localparam weight_t WEIGHT_TILDE = -10'sd1;
	localparam weight_t SYM_BIAS     = 10'sd256;

	typedef struct packed {
		logic              load;
		logic              start;
		logic              next_part;
		logic              adv_a;
		logic              adv_b;
		logic              first_clr;
		logic              first_upd;
		logic              finish;
		logic signed [1:0] sign;
	} pvc_cmd_t;

	typedef struct packed {
		logic              part;
		logic              ep_gt;
		logic              ep_lt;
		logic              a_in;
		logic              b_in;
		logic              a_dig;
		logic              b_dig;
		logic              a_zero;
		logic              b_zero;
		logic              w_ne;
		logic              w_lt;
		logic              first_ne;
		logic signed [1:0] first;
	} pvc_stat_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic weight_t char_weight(input logic [7:0] c);
		weight_t w;
		if (is_digit(c) || c == CH_NUL) begin
			w = '0;
		end else if ((c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z)) begin
			w = weight_t'({2'b00, c});
		end else if (c == CH_TILDE) begin
			w = WEIGHT_TILDE;
		end else begin
			w = weight_t'({2'b00, c}) + SYM_BIAS;
		end
		return w;
	endfunction

	function automatic logic rel_holds(input logic [2:0] rel, input logic signed [1:0] s);
		logic h;
		case (rel)
			REL_NONE: h = 1'b1;
			REL_EQ:   h = (s == SIGN_ZERO);
			REL_LT:   h = (s == SIGN_NEG);
			REL_LE:   h = (s != SIGN_POS);
			REL_GT:   h = (s == SIGN_POS);
			REL_GE:   h = (s != SIGN_NEG);
			default:  h = 1'b0;
		endcase
		return h;
	endfunction

endpackage

>>> rtl/package_version_compare.sv
// Load word: accepted whenever idle, one character per cycle back to back while idle.
// Compare word: result in the next cycle when the epochs differ; otherwise the FSM
// walks the version pair, then the revision pair if the versions are equal, through
// their registered-read RAMs, alternating fetch (S_F_*) and evaluate (S_E_*) states.
// Reset (arst_n low) empties all four stores and clears ovf_q and any pending result.
module package_version_compare #(
	parameter int MAX_LEN = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              cmd,
	input  logic [1:0]        slot,
	input  logic [7:0]        ch,
	input  logic [31:0]       epoch_a,
	input  logic [31:0]       epoch_b,
	input  logic [2:0]        relation,
	output logic              out_valid,
	input  logic              out_ready,
	output logic signed [1:0] order_sign,
	output logic              holds,
	output logic              overflow
);
	import pvc_pkg::*;

	pvc_cmd_t  ctl;
	pvc_stat_t stat;

	// Controller: owns the handshake and the walk sequence. It accepts load words
	// whenever idle, even while a result waits in the output register, and holds
	// off compare words until that result has been taken.
	pvc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	// Datapath: four character RAMs with their fill counters, the walk indices,
	// the weight and digit comparators and the result register. Fill counters
	// and the overflow flag drop to zero as each result is registered.
	pvc_dp #(
		.MAX_LEN (MAX_LEN)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.stat       (stat),
		.slot       (slot),
		.ch         (ch),
		.epoch_a    (epoch_a),
		.epoch_b    (epoch_b),
		.relation   (relation),
		.order_sign (order_sign),
		.holds      (holds),
		.overflow   (overflow)
	);

endmodule

>>> rtl/pvc_ram.sv
module pvc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/pvc_dp.sv
module pvc_dp #(
	parameter int MAX_LEN = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pvc_pkg::pvc_cmd_t  ctl,
	output pvc_pkg::pvc_stat_t stat,
	input  logic [1:0]         slot,
	input  logic [7:0]         ch,
	input  logic [31:0]        epoch_a,
	input  logic [31:0]        epoch_b,
	input  logic [2:0]         relation,
	output logic signed [1:0]  order_sign,
	output logic               holds,
	output logic               overflow
);
	import pvc_pkg::*;

	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int LW = $clog2(MAX_LEN + 1);

	logic [LW-1:0] len_va_q, len_ra_q, len_vb_q, len_rb_q;
	logic [LW-1:0] len_sel, la, lb;
	logic [LW-1:0] i_q, j_q;
	logic          part_q;
	logic          ovf_q;
	logic signed [1:0] first_q;
	logic [2:0]    rel_q, rel_sel;
	logic signed [1:0] order_sign_q;
	logic          holds_q, overflow_q;
	logic          full, wr_ok;
	logic [7:0]    rd_va, rd_ra, rd_vb, rd_rb;
	logic [7:0]    a_data, b_data, a_ch, b_ch;
	weight_t       wa, wb;

	// Store fill level of the slot being loaded
	always_comb begin
		case (slot)
			SLOT_VER_A: len_sel = len_va_q;
			SLOT_REV_A: len_sel = len_ra_q;
			SLOT_VER_B: len_sel = len_vb_q;
			default:    len_sel = len_rb_q;
		endcase
	end

	assign full  = (len_sel == LW'(MAX_LEN));
	assign wr_ok = ctl.load && (ch != CH_NUL) && !full;

	pvc_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_ram_va (
		.clk(clk), .we(wr_ok && slot == SLOT_VER_A), .waddr(len_sel[AW-1:0]),
		.wdata(ch), .raddr(i_q[AW-1:0]), .rdata(rd_va)
	);
	pvc_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_ram_ra (
		.clk(clk), .we(wr_ok && slot == SLOT_REV_A), .waddr(len_sel[AW-1:0]),
		.wdata(ch), .raddr(i_q[AW-1:0]), .rdata(rd_ra)
	);
	pvc_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_ram_vb (
		.clk(clk), .we(wr_ok && slot == SLOT_VER_B), .waddr(len_sel[AW-1:0]),
		.wdata(ch), .raddr(j_q[AW-1:0]), .rdata(rd_vb)
	);
	pvc_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_ram_rb (
		.clk(clk), .we(wr_ok && slot == SLOT_REV_B), .waddr(len_sel[AW-1:0]),
		.wdata(ch), .raddr(j_q[AW-1:0]), .rdata(rd_rb)
	);

	assign a_data = part_q ? rd_ra : rd_va;
	assign b_data = part_q ? rd_rb : rd_vb;
	assign la     = part_q ? len_ra_q : len_va_q;
	assign lb     = part_q ? len_rb_q : len_vb_q;

	// End of a string reads as NUL
	assign a_ch = (i_q < la) ? a_data : CH_NUL;
	assign b_ch = (j_q < lb) ? b_data : CH_NUL;
	assign wa   = char_weight(a_ch);
	assign wb   = char_weight(b_ch);

	assign stat.part     = part_q;
	assign stat.ep_gt    = (epoch_a > epoch_b);
	assign stat.ep_lt    = (epoch_a < epoch_b);
	assign stat.a_in     = (i_q < la);
	assign stat.b_in     = (j_q < lb);
	assign stat.a_dig    = is_digit(a_data);
	assign stat.b_dig    = is_digit(b_data);
	assign stat.a_zero   = (a_data == CH_ZERO);
	assign stat.b_zero   = (b_data == CH_ZERO);
	assign stat.w_ne     = (wa != wb);
	assign stat.w_lt     = (wa < wb);
	assign stat.first_ne = (first_q != SIGN_ZERO);
	assign stat.first    = first_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_va_q <= '0;
			len_ra_q <= '0;
			len_vb_q <= '0;
			len_rb_q <= '0;
			ovf_q    <= 1'b0;
		end else if (ctl.finish) begin
			len_va_q <= '0;
			len_ra_q <= '0;
			len_vb_q <= '0;
			len_rb_q <= '0;
			ovf_q    <= 1'b0;
		end else if (wr_ok) begin
			case (slot)
				SLOT_VER_A: len_va_q <= len_va_q + LW'(1);
				SLOT_REV_A: len_ra_q <= len_ra_q + LW'(1);
				SLOT_VER_B: len_vb_q <= len_vb_q + LW'(1);
				default:    len_rb_q <= len_rb_q + LW'(1);
			endcase
		end else if (ctl.load && ch != CH_NUL && full) begin
			ovf_q <= 1'b1;
		end
	end

	// Walk indices, active string pair and first differing digit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_q  <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
			first_q <= SIGN_ZERO;
		end else if (ctl.start || ctl.next_part) begin
			part_q  <= ctl.next_part;
			i_q     <= '0;
			j_q     <= '0;
			first_q <= SIGN_ZERO;
		end else begin
			if (ctl.adv_a) begin
				i_q <= i_q + LW'(1);
			end
			if (ctl.adv_b) begin
				j_q <= j_q + LW'(1);
			end
			if (ctl.first_clr) begin
				first_q <= SIGN_ZERO;
			end else if (ctl.first_upd && first_q == SIGN_ZERO && a_data != b_data) begin
				first_q <= (a_data < b_data) ? SIGN_NEG : SIGN_POS;
			end
		end
	end

	assign rel_sel = ctl.start ? relation : rel_q;

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rel_q <= relation;
		end
		if (ctl.finish) begin
			order_sign_q <= ctl.sign;
			holds_q      <= rel_holds(rel_sel, ctl.sign);
			overflow_q   <= ovf_q;
		end
	end

	assign order_sign = order_sign_q;
	assign holds      = holds_q;
	assign overflow   = overflow_q;

endmodule

>>> rtl/pvc_ctrl.sv
`include "assert_macros.svh"

module pvc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               cmd,
	output logic               out_valid,
	input  logic               out_ready,
	input  pvc_pkg::pvc_stat_t stat,
	output pvc_pkg::pvc_cmd_t  ctl
);
	import pvc_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_F_NONDIG,
		S_E_NONDIG,
		S_F_ZEROS,
		S_E_ZEROS,
		S_F_DIGITS,
		S_E_DIGITS
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   accept;
	logic   nd_a, nd_b, za, zb, da, db;

	// Loads may stream in while a result waits; a compare needs the output free
	assign in_ready = (state_q == S_IDLE) && (!out_valid_q || cmd == CMD_LOAD);
	assign accept   = in_valid && in_ready;

	assign nd_a = stat.a_in && !stat.a_dig;
	assign nd_b = stat.b_in && !stat.b_dig;
	assign za   = stat.a_in && stat.a_zero;
	assign zb   = stat.b_in && stat.b_zero;
	assign da   = stat.a_in && stat.a_dig;
	assign db   = stat.b_in && stat.b_dig;

	always_comb begin
		ctl     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (cmd == CMD_LOAD) begin
						ctl.load = 1'b1;
					end else begin
						ctl.start = 1'b1;
						if (stat.ep_gt) begin
							ctl.finish = 1'b1;
							ctl.sign   = SIGN_POS;
						end else if (stat.ep_lt) begin
							ctl.finish = 1'b1;
							ctl.sign   = SIGN_NEG;
						end else begin
							state_d = S_F_NONDIG;
						end
					end
				end
			end
			S_F_NONDIG: state_d = S_E_NONDIG;
			S_E_NONDIG: begin
				if (!stat.a_in && !stat.b_in) begin
					// pair equal: move to the revisions, or report equal
					if (!stat.part) begin
						ctl.next_part = 1'b1;
						state_d       = S_F_NONDIG;
					end else begin
						ctl.finish = 1'b1;
						ctl.sign   = SIGN_ZERO;
						state_d    = S_IDLE;
					end
				end else if (nd_a || nd_b) begin
					if (stat.w_ne) begin
						ctl.finish = 1'b1;
						ctl.sign   = stat.w_lt ? SIGN_NEG : SIGN_POS;
						state_d    = S_IDLE;
					end else begin
						ctl.adv_a = stat.a_in;
						ctl.adv_b = stat.b_in;
						state_d   = S_F_NONDIG;
					end
				end else begin
					state_d = S_E_ZEROS;
				end
			end
			S_F_ZEROS: state_d = S_E_ZEROS;
			S_E_ZEROS: begin
				if (za || zb) begin
					ctl.adv_a = za;
					ctl.adv_b = zb;
					state_d   = S_F_ZEROS;
				end else begin
					state_d = S_E_DIGITS;
				end
			end
			S_F_DIGITS: state_d = S_E_DIGITS;
			S_E_DIGITS: begin
				if (da && db) begin
					ctl.first_upd = 1'b1;
					ctl.adv_a     = 1'b1;
					ctl.adv_b     = 1'b1;
					state_d       = S_F_DIGITS;
				end else if (da) begin
					ctl.finish = 1'b1;
					ctl.sign   = SIGN_POS;
					state_d    = S_IDLE;
				end else if (db) begin
					ctl.finish = 1'b1;
					ctl.sign   = SIGN_NEG;
					state_d    = S_IDLE;
				end else if (stat.first_ne) begin
					ctl.finish = 1'b1;
					ctl.sign   = stat.first;
					state_d    = S_IDLE;
				end else begin
					ctl.first_clr = 1'b1;
					state_d       = S_F_NONDIG;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`ASSERT_NEVER(a_cmp_while_full, clk, arst_n, accept && cmd == CMD_COMPARE && out_valid_q, "compare taken while result pending")
	`ASSERT_NEVER(a_ready_busy, clk, arst_n, in_ready && state_q != S_IDLE, "input ready during a walk")
	`ASSERT_NEVER(a_finish_clobber, clk, arst_n, ctl.finish && out_valid_q, "result overwritten before taken")
	`ASSERT_PROP(a_part_once, clk, arst_n, ctl.next_part |-> !stat.part, "revision pair entered twice")

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

	import pvc_pkg::*;

	localparam int     STORE_DEPTH     = 64;
	localparam int     HALF_PERIOD     = 6;
	localparam int     RESET_CYCLES    = 10;
	localparam longint LIMIT_NS        = 64'd18_000_000;
	// a compare may walk both string pairs before its result arrives
	localparam int     SETTLE_CYCLES   = 8 * STORE_DEPTH + 64;
	localparam int     WORDS_PER_PHASE = 425;
	localparam int     DRAIN_EVERY     = 37;

	// relation codes past the defined set; the block must report them as not holding
	localparam logic [2:0] REL_CODE_6 = 3'd6;
	localparam logic [2:0] REL_CODE_7 = 3'd7;

	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_COLON = 8'h3A;

	class version_ledger;

		typedef struct packed {
			logic signed [1:0] sign;
			logic              holds;
			logic              ovf;
		} verdict_t;

		logic [7:0] chars [4][STORE_DEPTH];
		int         lens [4];
		logic       ovf_seen;
		verdict_t   due[$];
		int         fails;

		function new();
			lens = '{default: 0};
			ovf_seen = 1'b0;
			fails = 0;
		endfunction

		function logic numeral(logic [7:0] c);
			return (c >= pvc_pkg::CH_ZERO) && (c <= pvc_pkg::CH_NINE);
		endfunction

		// Digits and end of string weigh nothing, tilde sorts below everything.
		function int rank(logic [7:0] c);
			if (numeral(c))
				return 0;
			if ((c >= pvc_pkg::CH_UP_A && c <= pvc_pkg::CH_UP_Z) ||
			    (c >= pvc_pkg::CH_LO_A && c <= pvc_pkg::CH_LO_Z))
				return int'(c);
			if (c == pvc_pkg::CH_TILDE)
				return -1;
			if (c != pvc_pkg::CH_NUL)
				return int'(c) + 256;
			return 0;
		endfunction

		function logic [7:0] at(int s, int k);
			return (k < lens[s]) ? chars[s][k] : pvc_pkg::CH_NUL;
		endfunction

		function int part_order(int sa, int sb);
			int i, j, first, wa, wb;
			i = 0;
			j = 0;
			while (i < lens[sa] || j < lens[sb]) begin
				first = 0;
				while ((i < lens[sa] && !numeral(at(sa, i))) ||
				       (j < lens[sb] && !numeral(at(sb, j)))) begin
					wa = rank(at(sa, i));
					wb = rank(at(sb, j));
					if (wa != wb)
						return (wa < wb) ? -1 : 1;
					if (i < lens[sa])
						i++;
					if (j < lens[sb])
						j++;
				end
				while (i < lens[sa] && at(sa, i) == pvc_pkg::CH_ZERO)
					i++;
				while (j < lens[sb] && at(sb, j) == pvc_pkg::CH_ZERO)
					j++;
				while (i < lens[sa] && j < lens[sb] && numeral(at(sa, i)) && numeral(at(sb, j))) begin
					if (first == 0 && at(sa, i) != at(sb, j))
						first = (at(sa, i) < at(sb, j)) ? -1 : 1;
					i++;
					j++;
				end
				if (i < lens[sa] && numeral(at(sa, i)))
					return 1;
				if (j < lens[sb] && numeral(at(sb, j)))
					return -1;
				if (first != 0)
					return first;
			end
			return 0;
		endfunction

		function void take_word(logic cmd, logic [1:0] slot, logic [7:0] ch,
		                        logic [31:0] ea, logic [31:0] eb, logic [2:0] rel);
			int r;
			verdict_t v;
			if (cmd == pvc_pkg::CMD_LOAD) begin
				if (ch != pvc_pkg::CH_NUL) begin
					if (lens[slot] < STORE_DEPTH) begin
						chars[slot][lens[slot]] = ch;
						lens[slot]++;
					end else begin
						ovf_seen = 1'b1;
					end
				end
				return;
			end
			if (ea > eb) begin
				r = 1;
			end else if (ea < eb) begin
				r = -1;
			end else begin
				r = part_order(pvc_pkg::SLOT_VER_A, pvc_pkg::SLOT_VER_B);
				if (r == 0)
					r = part_order(pvc_pkg::SLOT_REV_A, pvc_pkg::SLOT_REV_B);
			end
			v.sign = (r < 0) ? pvc_pkg::SIGN_NEG : ((r > 0) ? pvc_pkg::SIGN_POS : pvc_pkg::SIGN_ZERO);
			case (rel)
				pvc_pkg::REL_NONE: v.holds = 1'b1;
				pvc_pkg::REL_EQ:   v.holds = (r == 0);
				pvc_pkg::REL_LT:   v.holds = (r < 0);
				pvc_pkg::REL_LE:   v.holds = (r <= 0);
				pvc_pkg::REL_GT:   v.holds = (r > 0);
				pvc_pkg::REL_GE:   v.holds = (r >= 0);
				default:           v.holds = 1'b0;
			endcase
			v.ovf = ovf_seen;
			due.push_back(v);
			lens = '{default: 0};
			ovf_seen = 1'b0;
		endfunction

		function void check_verdict(logic signed [1:0] sign, logic holds, logic ovf);
			verdict_t v;
			if (due.size() == 0) begin
				$error("result with no compare outstanding: order_sign %0d holds %0b overflow %0b",
				       sign, holds, ovf);
				fails++;
				return;
			end
			v = due.pop_front();
			if (sign !== v.sign) begin
				$error("order_sign: expected %0d, got %0d", v.sign, sign);
				fails++;
			end
			if (holds !== v.holds) begin
				$error("holds: expected %0b, got %0b", v.holds, holds);
				fails++;
			end
			if (ovf !== v.ovf) begin
				$error("overflow: expected %0b, got %0b", v.ovf, ovf);
				fails++;
			end
		endfunction

		function int waiting();
			return due.size();
		endfunction

		function void close();
			if (due.size() != 0) begin
				$error("%0d compare results never arrived", due.size());
				fails += due.size();
			end
		endfunction

	endclass

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic              cmd;
	logic [1:0]        slot;
	logic [7:0]        ch;
	logic [31:0]       epoch_a;
	logic [31:0]       epoch_b;
	logic [2:0]        relation;
	logic              out_valid;
	logic              out_ready;
	logic signed [1:0] order_sign;
	logic              holds;
	logic              overflow;

	int send_idle_pct;
	int recv_stall_pct;
	int words_sent;
	int case_count;

	// pending text for the four stores, streamed out interleaved
	logic [7:0] text_q [4][$];

	version_ledger ledger = new();

	package_version_compare #(
		.MAX_LEN(STORE_DEPTH)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.slot       (slot),
		.ch         (ch),
		.epoch_a    (epoch_a),
		.epoch_b    (epoch_b),
		.relation   (relation),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.order_sign (order_sign),
		.holds      (holds),
		.overflow   (overflow)
	);

	initial clk = 1'b0;
	always #(HALF_PERIOD) clk = ~clk;

	// Stall the result side per cycle at the current rate; change only on the falling edge.
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Sample both handshakes at the rising edge: check a finished result first,
	// then note the word accepted at the same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				ledger.check_verdict(order_sign, holds, overflow);
			if (in_valid && in_ready)
				ledger.take_word(cmd, slot, ch, epoch_a, epoch_b, relation);
		end
	end

	// Hard stop in case the block hangs.
	initial begin
		#(LIMIT_NS);
		$display("package_version_compare: mismatch");
		$finish;
	end

	// Present one word: idle first at the sender's rate, then hold valid and the
	// payload until the block takes it.
	task automatic send_word(input logic c, input logic [1:0] s, input logic [7:0] b,
	                         input logic [31:0] ea, input logic [31:0] eb,
	                         input logic [2:0] rel);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= c;
		slot     <= s;
		ch       <= b;
		epoch_a  <= ea;
		epoch_b  <= eb;
		relation <= rel;
		do @(posedge clk); while (!in_ready);
		// a zero byte is dropped by the block, so do not count it
		if (c == CMD_COMPARE || b != CH_NUL)
			words_sent++;
	endtask

	// Load word: epochs and relation are don't-care, so fill them with noise.
	task automatic load_char(input logic [1:0] s, input logic [7:0] b);
		send_word(CMD_LOAD, s, b, $urandom(), $urandom(), 3'($urandom_range(7)));
	endtask

	// Compare word: slot and ch are don't-care here.
	task automatic compare_word(input logic [31:0] ea, input logic [31:0] eb,
	                            input logic [2:0] rel);
		send_word(CMD_COMPARE, 2'($urandom_range(3)), 8'($urandom_range(255)), ea, eb, rel);
	endtask

	// Drop valid, then hold off until every outstanding compare has reported.
	task automatic wait_for_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (ledger.waiting() != 0)
			@(negedge clk);
	endtask

	// Drain the pending text into the block, picking stores at random so the
	// loads of different strings interleave; slip in the odd zero byte.
	task automatic stream_text();
		int left;
		int s;
		left = text_q[0].size() + text_q[1].size() + text_q[2].size() + text_q[3].size();
		while (left > 0) begin
			s = $urandom_range(3);
			if (text_q[s].size() == 0)
				continue;
			if ($urandom_range(99) < 3)
				load_char(2'(s), CH_NUL);
			load_char(2'(s), text_q[s].pop_front());
			left--;
		end
	endtask

	function automatic void fill_text(int s, string t);
		for (int k = 0; k < t.len(); k++)
			text_q[s].push_back(t[k]);
	endfunction

	task automatic run_case(input string va, input string ra, input string vb, input string rb,
	                        input logic [31:0] ea, input logic [31:0] eb, input logic [2:0] rel);
		fill_text(SLOT_VER_A, va);
		fill_text(SLOT_REV_A, ra);
		fill_text(SLOT_VER_B, vb);
		fill_text(SLOT_REV_B, rb);
		stream_text();
		compare_word(ea, eb, rel);
	endtask

	// Mostly version-like characters, with leading zeros, tildes, separators and
	// the occasional arbitrary byte.
	function automatic logic [7:0] pick_char();
		int p;
		p = $urandom_range(99);
		if (p < 35)
			return CH_ZERO + 8'($urandom_range(9));
		if (p < 45)
			return CH_ZERO;
		if (p < 60)
			return CH_LO_A + 8'($urandom_range(25));
		if (p < 66)
			return CH_UP_A + 8'($urandom_range(25));
		if (p < 76)
			return CH_DOT;
		if (p < 82)
			return CH_TILDE;
		if (p < 86)
			return CH_PLUS;
		if (p < 90)
			return CH_DASH;
		if (p < 93)
			return CH_COLON;
		return 8'($urandom_range(255, 1));
	endfunction

	function automatic void rand_text(int s, int n);
		for (int k = 0; k < n; k++)
			text_q[s].push_back(pick_char());
	endfunction

	// Build the B side from the A side with at most one small edit, so that the walk
	// often gets deep into both strings before it finds a difference.
	function automatic void derive_text(int from, int to);
		int pick;
		int pos;
		text_q[to] = text_q[from];
		pick = $urandom_range(5);
		case (pick)
			1: begin
				if (text_q[to].size() > 0) begin
					pos = $urandom_range(text_q[to].size() - 1);
					text_q[to][pos] = pick_char();
				end
			end
			2: text_q[to].push_back(pick_char());
			3: begin
				if (text_q[to].size() > 0)
					void'(text_q[to].pop_back());
			end
			4: begin
				pos = $urandom_range(text_q[to].size());
				text_q[to].insert(pos, CH_ZERO);
			end
			5: text_q[to].push_back(CH_TILDE);
			default: ;
		endcase
	endfunction

	function automatic void make_case();
		int mode;
		int s;
		for (int k = 0; k < 4; k++)
			text_q[k].delete();
		mode = $urandom_range(99);
		// now and then compare with every store empty
		if (mode < 4)
			return;
		rand_text(SLOT_VER_A, $urandom_range(8));
		rand_text(SLOT_REV_A, $urandom_range(3));
		if ($urandom_range(1) != 0)
			derive_text(SLOT_VER_A, SLOT_VER_B);
		else
			rand_text(SLOT_VER_B, $urandom_range(8));
		if ($urandom_range(2) != 0)
			derive_text(SLOT_REV_A, SLOT_REV_B);
		else
			rand_text(SLOT_REV_B, $urandom_range(3));
		// rarely push one store up to or past its capacity
		if (mode >= 97) begin
			s = $urandom_range(3);
			rand_text(s, STORE_DEPTH - text_q[s].size() + $urandom_range(6));
		end
	endfunction

	task automatic random_compare();
		int p;
		logic [31:0] ea;
		logic [31:0] eb;
		p = $urandom_range(99);
		if (p < 70) begin
			// equal epochs, so the strings decide
			ea = ($urandom_range(1) != 0) ? 32'($urandom_range(3)) : $urandom();
			eb = ea;
		end else if (p < 75) begin
			ea = ($urandom_range(1) != 0) ? 32'hFFFF_FFFF : 32'h0;
			eb = ~ea;
		end else begin
			ea = $urandom();
			eb = $urandom();
		end
		compare_word(ea, eb, 3'($urandom_range(7)));
	endtask

	initial begin
		in_valid       = 1'b0;
		cmd            = CMD_LOAD;
		slot           = SLOT_VER_A;
		ch             = CH_NUL;
		epoch_a        = '0;
		epoch_b        = '0;
		relation       = REL_NONE;
		out_ready      = 1'b0;
		arst_n         = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		words_sent     = 0;
		case_count     = 0;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed cases: empty stores, tilde before release, revision decides,
		// leading zeros, epoch extremes, symbols and high bytes, codes 6 and 7.
		run_case("", "", "", "", 32'h0, 32'h0, REL_NONE);
		run_case("1.0~rc1", "", "1.0", "", 32'h0, 32'h0, REL_LT);
		run_case("1.0", "1", "1.0", "2", 32'h0, 32'h0, REL_EQ);
		run_case("007a", "", "7b", "", 32'h0, 32'h0, REL_GT);
		run_case("2", "", "10", "", 32'hFFFF_FFFF, 32'hFFFF_FFFF, REL_GE);
		run_case("9", "", "1", "", 32'h0, 32'hFFFF_FFFF, REL_LE);
		run_case("1\200", "", "1z", "", 32'h7, 32'h7, REL_CODE_6);
		run_case("1.0", "", "1.0.0", "~", 32'h0, 32'h0, REL_CODE_7);
		run_case("~~", "Z", "~", "a", 32'h5, 32'h5, REL_LT);
		run_case("1+A", "", "1:\377", "", 32'h8000_0000, 32'h8000_0000, REL_GT);

		// Store full: overrun version A and revision B, then compare once with
		// the flag set and once more to see it cleared.
		repeat (STORE_DEPTH + 2) text_q[SLOT_VER_A].push_back(CH_ZERO + 8'd1);
		repeat (STORE_DEPTH) text_q[SLOT_VER_B].push_back(CH_ZERO + 8'd1);
		repeat (STORE_DEPTH + 1) text_q[SLOT_REV_B].push_back(CH_LO_A);
		stream_text();
		compare_word(32'h0, 32'h0, REL_EQ);
		compare_word(32'h0, 32'h0, REL_EQ);

		// Zero byte: must leave the store untouched.
		load_char(SLOT_VER_A, CH_NUL);
		load_char(SLOT_VER_B, CH_ZERO + 8'd1);
		compare_word(32'h1, 32'h1, REL_LT);

		wait_for_results();

		// Random part in four idling phases.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
				default: begin send_idle_pct = 31; recv_stall_pct = 31; end
			endcase
			words_sent = 0;
			while (words_sent < WORDS_PER_PHASE) begin
				make_case();
				stream_text();
				case_count++;
				// now and then let the block go completely idle before the compare
				if (case_count % DRAIN_EVERY == 0)
					wait_for_results();
				random_compare();
			end
			wait_for_results();
		end

		@(negedge clk);
		in_valid <= 1'b0;
		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		ledger.close();
		if (ledger.fails == 0) begin
			$display("package_version_compare: match");
		end else begin
			$display("package_version_compare: mismatch");
		end
		$finish;
	end

endmodule
